>>> src/hlfs_pkg.sv
// Shared constants, queue entry type and FCS-16 helper function for the frame sender.
// No dependencies; imported by every module of the block.
`default_nettype none

package hlfs_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE  = 8'h7d;
	localparam logic [7:0] ESC_XOR   = 8'h20;
	localparam logic [15:0] FCS_INIT = 16'hffff;
	localparam logic [15:0] FCS_POLY = 16'h8408;

	localparam logic [7:0] HDR_ADDR  = 8'hff;
	localparam logic [7:0] HDR_CTRL  = 8'h03;
	localparam logic [7:0] HDR_PROTO_HI = 8'h00;
	localparam logic [7:0] HDR_PROTO_LO = 8'h21;

	localparam int QUEUE_DEPTH = 4;

	// One accepted payload byte after classification. fcs holds the complemented
	// FCS and is meaningful only when last is set.
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] fcs;
	} hlfs_entry_t;

	// Reflected CRC-16/X-25 update over one byte.
	function automatic logic [15:0] fcs_byte(input logic [15:0] fcs, input logic [7:0] b);
		logic [15:0] f;
		f = fcs ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (f[0]) begin
				f = (f >> 1) ^ FCS_POLY;
			end else begin
				f = f >> 1;
			end
		end
		return f;
	endfunction

	// FCS after the four header bytes, folded at elaboration.
	localparam logic [15:0] HDR_FCS = fcs_byte(fcs_byte(fcs_byte(fcs_byte(FCS_INIT,
		HDR_ADDR), HDR_CTRL), HDR_PROTO_HI), HDR_PROTO_LO);

endpackage

`default_nettype wire

>>> src/hlfs_front.sv
// Front end: accepts payload bytes, keeps the running FCS and builds queue entries.
// Depends on hlfs_pkg.
`default_nettype none

module hlfs_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           in_data,
	input  wire logic                 in_first,
	input  wire logic                 in_last,
	input  wire logic                 q_full,
	output logic                      q_push,
	output hlfs_pkg::hlfs_entry_t     q_entry
);
	import hlfs_pkg::*;

	logic [15:0] fcs_q;
	logic [15:0] fcs_base;
	logic [15:0] fcs_next;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		fcs_base       = in_first ? HDR_FCS : fcs_q;
		fcs_next       = fcs_byte(fcs_base, in_data);
		q_entry.data   = in_data;
		q_entry.first  = in_first;
		q_entry.last   = in_last;
		q_entry.fcs    = ~fcs_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcs_q <= FCS_INIT;
		end else if (q_push) begin
			fcs_q <= in_last ? FCS_INIT : fcs_next;
		end
	end

endmodule

`default_nettype wire

>>> src/hlfs_queue.sv
// Short FIFO of classified entries between the front and back ends.
// Depends on hlfs_pkg for the entry type.
`default_nettype none

module hlfs_queue #(
	parameter int DEPTH = hlfs_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire hlfs_pkg::hlfs_entry_t push_entry,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      empty,
	output hlfs_pkg::hlfs_entry_t     head
);
	import hlfs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	hlfs_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/hlfs_back.sv
// Back end: walks each entry through flag, header, escaped data, FCS and closing flag as its
// first/last bits select, one line byte per cycle unless stalled, into a registered output. Depends on hlfs_pkg.
`default_nettype none

module hlfs_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire hlfs_pkg::hlfs_entry_t q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic                       out_run_last,
	output logic                       out_frame_end
);
	import hlfs_pkg::*;

	localparam logic [3:0] P_FLAG  = 4'd0;
	localparam logic [3:0] P_H0    = 4'd1;
	localparam logic [3:0] P_H1    = 4'd2;
	localparam logic [3:0] P_H2    = 4'd3;
	localparam logic [3:0] P_H3    = 4'd4;
	localparam logic [3:0] P_DATA  = 4'd5;
	localparam logic [3:0] P_FLO   = 4'd6;
	localparam logic [3:0] P_FHI   = 4'd7;
	localparam logic [3:0] P_CLOSE = 4'd8;

	logic [3:0] ph_q;
	logic       busy_q;
	logic       esc_q;

	logic [3:0] cur_ph;
	logic [3:0] next_ph;
	logic [7:0] src_byte;
	logic [7:0] line_byte;
	logic       escapable;
	logic       need_esc;
	logic       phase_done;
	logic       entry_done;
	logic       load;
	logic       step;

	assign load  = !out_valid || out_ready;
	assign step  = load && !q_empty;
	assign q_pop = step && entry_done;

	always_comb begin
		cur_ph = busy_q ? ph_q : (q_head.first ? P_FLAG : P_DATA);

		unique case (cur_ph)
			P_FLO:   src_byte = q_head.fcs[7:0];
			P_FHI:   src_byte = q_head.fcs[15:8];
			default: src_byte = q_head.data;
		endcase

		escapable  = (cur_ph == P_DATA) || (cur_ph == P_FLO) || (cur_ph == P_FHI);
		need_esc   = escapable && ((src_byte == ESC_BYTE) || (src_byte == FLAG_BYTE));
		phase_done = !need_esc || esc_q;

		unique case (cur_ph)
			P_FLAG, P_CLOSE: line_byte = FLAG_BYTE;
			P_H0:            line_byte = HDR_ADDR;
			P_H1:            line_byte = HDR_CTRL;
			P_H2:            line_byte = HDR_PROTO_HI;
			P_H3:            line_byte = HDR_PROTO_LO;
			default: begin
				if (esc_q) begin
					line_byte = src_byte ^ ESC_XOR;
				end else if (need_esc) begin
					line_byte = ESC_BYTE;
				end else begin
					line_byte = src_byte;
				end
			end
		endcase

		unique case (cur_ph)
			P_FLAG:  next_ph = P_H0;
			P_H0:    next_ph = P_H1;
			P_H1:    next_ph = P_H2;
			P_H2:    next_ph = P_H3;
			P_H3:    next_ph = P_DATA;
			P_DATA:  next_ph = P_FLO;
			P_FLO:   next_ph = P_FHI;
			P_FHI:   next_ph = P_CLOSE;
			default: next_ph = P_FLAG;
		endcase

		entry_done = phase_done &&
			(((cur_ph == P_DATA) && !q_head.last) || (cur_ph == P_CLOSE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= P_FLAG;
			busy_q    <= 1'b0;
			esc_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= step;
			end
			if (step) begin
				if (entry_done) begin
					busy_q <= 1'b0;
					esc_q  <= 1'b0;
				end else begin
					busy_q <= 1'b1;
					if (phase_done) begin
						ph_q  <= next_ph;
						esc_q <= 1'b0;
					end else begin
						ph_q  <= cur_ph;
						esc_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte      <= line_byte;
			out_run_last  <= entry_done;
			out_frame_end <= (cur_ph == P_CLOSE);
		end
	end

endmodule

`default_nettype wire

>>> src/hdlc_like_frame_sender_fcs16_core.sv
// HDLC-like PPP frame sender with FCS-16 (CRC-16/X-25), stream in and stream out.
// An accepted item is written into the queue; the back end then registers its line bytes
// into the single output byte register, where they are offered on the output stream.
// Throughput: one line byte per cycle unless the output stalls or the queue is empty, set by
// the single output byte register; an item yields up to twelve line bytes, two per escaped byte.
// Reset (arst_n, asynchronous, active low) empties the queue, drops any pending output
// and returns the running FCS to 0xffff.
`default_nettype none

module hdlc_like_frame_sender_fcs16_core #(
	parameter int QUEUE_DEPTH = hlfs_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	// Payload byte stream.
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic [0:0] s_axis_tuser,   // [0] first_byte
	input  wire logic       s_axis_tlast,   // last_byte

	// Framed line stream.
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic [0:0]      m_axis_tuser,   // [0] frame_end
	output logic            m_axis_tlast    // run_last
);
	import hlfs_pkg::*;

	// The front end folds each byte into the FCS the cycle it is accepted, so an
	// entry in the queue carries everything the back end needs, including the final
	// complemented FCS for a closing byte. The queue lets input keep flowing while
	// the back end is busy expanding headers and escapes.
	hlfs_entry_t q_entry;
	hlfs_entry_t q_head;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	hlfs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_first (s_axis_tuser[0]),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	hlfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	// The back end pops an entry only when it emits that entry's final line byte,
	// which is the byte that carries tlast.
	hlfs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata),
		.out_run_last  (m_axis_tlast),
		.out_frame_end (m_axis_tuser[0])
	);

endmodule

`default_nettype wire
